[rtl/vpid_pkg.sv]
`default_nettype none

package vpid_pkg;

  localparam int unsigned DIV_NUM_W = 52;
  localparam int unsigned DIV_BPC   = 4;
  localparam int unsigned DIV_STEPS = DIV_NUM_W / DIV_BPC;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned PP_LAST   = 3;

  localparam logic [31:0] Q_TENTH     = 32'd6554;
  localparam logic [31:0] Q_NEG_TENTH = ~Q_TENTH + 32'd1;
  localparam logic [31:0] Q_HALF      = 32'd32768;
  localparam logic [31:0] Q_CLAMP_INC = 32'd3276800;
  localparam logic [31:0] Q_CLAMP_ABS = 32'd327680;
  localparam logic [31:0] S32_MAX     = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN     = 32'h8000_0000;

  localparam logic [19:0] US_PER_S  = 20'd1000000;
  localparam logic [19:0] US_PER_MS = 20'd1000;
  localparam logic [19:0] US_FLOOR  = 20'd1000;

  localparam logic [47:0] GAIN_P_RST = 48'd10995116;
  localparam logic [47:0] GAIN_I_RST = 48'd109951;
  localparam logic [47:0] GAIN_D_RST = 48'd10995116;

  typedef enum logic [1:0] {
    REG_LOOP_MODE = 2'd0,
    REG_GAIN_P    = 2'd1,
    REG_GAIN_I    = 2'd2,
    REG_GAIN_D    = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } term_e;

  typedef struct packed {
    logic       capture;
    logic       calc_err;
    logic       prep;
    logic       div_step;
    logic       load_der_div;
    logic       int_upd;
    logic       der_upd;
    logic       term_load;
    logic       mul_step;
    logic       term_add;
    logic       finish;
    term_e      term;
    logic [1:0] pp;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic mode;
  } sts_t;

endpackage

`default_nettype wire

[rtl/vpid_ctrl.sv]
`default_nettype none

module vpid_ctrl
  import vpid_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_ERR  = 11'b000_0000_0010,
    S_PREP = 11'b000_0000_0100,
    S_DIVI = 11'b000_0000_1000,
    S_INT  = 11'b000_0001_0000,
    S_DIVD = 11'b000_0010_0000,
    S_DER  = 11'b000_0100_0000,
    S_TERM = 11'b000_1000_0000,
    S_MUL  = 11'b001_0000_0000,
    S_ADD  = 11'b010_0000_0000,
    S_FIN  = 11'b100_0000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  term_e            term_q, term_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      term_q  <= TERM_P;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      term_q  <= term_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    term_d  = term_q;
    cmd_o   = '0;
    cmd_o.term = term_q;
    cmd_o.pp   = cnt_q[1:0];
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_ERR;
        end
      end
      S_ERR: begin
        cmd_o.calc_err = 1'b1;
        state_d        = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = S_DIVI;
      end
      S_DIVI: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_INT;
        end
      end
      S_INT: begin
        cmd_o.int_upd = 1'b1;
        cnt_d         = '0;
        if (sts_i.mode) begin
          state_d = S_DER;
        end else begin
          cmd_o.load_der_div = 1'b1;
          state_d            = S_DIVD;
        end
      end
      S_DIVD: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_DER;
        end
      end
      S_DER: begin
        cmd_o.der_upd = 1'b1;
        term_d        = TERM_P;
        state_d       = S_TERM;
      end
      S_TERM: begin
        cmd_o.term_load = 1'b1;
        cnt_d           = '0;
        state_d         = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(PP_LAST)) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.term_add = 1'b1;
        case (term_q)
          TERM_P: begin
            term_d  = TERM_I;
            state_d = S_TERM;
          end
          TERM_I: begin
            term_d  = TERM_D;
            state_d = S_TERM;
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/vpid_datapath.sv]
`default_nettype none

module vpid_datapath
  import vpid_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [47:0]        cfg_data_i,
  input  logic signed [31:0] target_rpm_i,
  input  logic signed [31:0] measured_rpm_i,
  input  logic [19:0]        step_time_us_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] drive_value_o
);

  logic        mode_q;
  logic [47:0] gain_p_q, gain_i_q, gain_d_q;
  logic [31:0] prior_error_q, integral_q, held_q, prior_target_q;
  logic        out_valid_q;

  logic [31:0] tgt_q;
  logic [19:0] us_q;
  logic [31:0] err_q;
  logic        tchg_small_q, tchg_big_q;
  logic [DIV_NUM_W-1:0] der_mag_q;
  logic        der_neg_q;
  logic [19:0] ltf_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [19:0] rem_q, den_q;
  logic        dneg_q;
  logic [31:0] integ_q;
  logic [43:0] deriv_q;
  logic [47:0] tmag_q;
  logic        tneg_q;
  logic [95:0] prod_q;
  logic [55:0] oacc_q;
  logic [31:0] dout_q;

  logic [32:0] diff33, tdiff33, tmag33, ddiff33, dmag33;
  logic [31:0] err_d, err_mag;
  logic [DIV_NUM_W-1:0] int_prod, der_prod;
  logic [19:0] der_k;
  logic [DIV_NUM_W-1:0] step_quo;
  logic [19:0] step_rem;
  logic [20:0] trial;
  logic [33:0] qmag34, qs34, isum34, lim34, nlim34;
  logic        flip, izero;
  logic [31:0] integ_d;
  logic [43:0] dmag44, deriv_d;
  logic        dsign;
  logic [43:0] tval44, tmag44;
  logic [47:0] gain_sel;
  logic [23:0] mop, gop;
  logic [47:0] pp48;
  logic [95:0] ppx;
  logic [55:0] tres56;
  logic        fits, opos, bump;
  logic [31:0] osat, omag, ofinal;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      gain_p_q <= GAIN_P_RST;
      gain_i_q <= GAIN_I_RST;
      gain_d_q <= GAIN_D_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_LOOP_MODE: mode_q   <= cfg_data_i[0];
        REG_GAIN_P:    gain_p_q <= cfg_data_i;
        REG_GAIN_I:    gain_i_q <= cfg_data_i;
        REG_GAIN_D:    gain_d_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // error and setpoint change
  assign diff33  = {target_rpm_i[31], target_rpm_i} - {measured_rpm_i[31], measured_rpm_i};
  assign tdiff33 = {tgt_q[31], tgt_q} - {prior_target_q[31], prior_target_q};
  assign tmag33  = tdiff33[32] ? (~tdiff33 + 33'd1) : tdiff33;

  always_comb begin
    if (diff33[32] ^ diff33[31]) begin
      err_d = diff33[32] ? S32_MIN : S32_MAX;
    end else begin
      err_d = diff33[31:0];
    end
  end

  // integral and derivative numerators
  assign err_mag  = err_q[31] ? (~err_q + 32'd1) : err_q;
  assign int_prod = DIV_NUM_W'(err_mag) * DIV_NUM_W'(us_q);
  assign ddiff33  = {err_q[31], err_q} - {prior_error_q[31], prior_error_q};
  assign dmag33   = ddiff33[32] ? (~ddiff33 + 33'd1) : ddiff33;
  assign der_k    = mode_q ? US_PER_MS : US_PER_S;
  assign der_prod = DIV_NUM_W'(dmag33) * DIV_NUM_W'(der_k);

  // restoring divider, DIV_BPC quotient bits per cycle
  always_comb begin
    step_quo = quo_q;
    step_rem = rem_q;
    trial    = '0;
    for (int i = 0; i < DIV_BPC; i++) begin
      trial    = {step_rem, step_quo[DIV_NUM_W-1]};
      step_quo = {step_quo[DIV_NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial       = trial - {1'b0, den_q};
        step_quo[0] = 1'b1;
      end
      step_rem = trial[19:0];
    end
  end

  // integral update with anti-windup
  assign qmag34 = {2'b00, quo_q[31:0]};
  assign qs34   = dneg_q ? (~qmag34 + 34'd1) : qmag34;
  assign isum34 = {{2{integral_q[31]}}, integral_q} + qs34;
  assign lim34  = {2'b00, (mode_q ? Q_CLAMP_ABS : Q_CLAMP_INC)};
  assign nlim34 = ~lim34 + 34'd1;
  assign flip   = (!err_q[31] && (err_q != '0) && prior_error_q[31])
               || (err_q[31] && !prior_error_q[31] && (prior_error_q != '0));
  assign izero  = flip || (!mode_q && ((err_mag < Q_TENTH) || tchg_small_q));

  always_comb begin
    if (izero) begin
      integ_d = '0;
    end else if ($signed(isum34) > $signed(lim34)) begin
      integ_d = lim34[31:0];
    end else if ($signed(isum34) < $signed(nlim34)) begin
      integ_d = nlim34[31:0];
    end else begin
      integ_d = isum34[31:0];
    end
  end

  assign dmag44  = mode_q ? der_mag_q[43:0] : quo_q[43:0];
  assign dsign   = mode_q ? der_neg_q : dneg_q;
  assign deriv_d = dsign ? (~dmag44 + 44'd1) : dmag44;

  // gain products from 24x24 partial products
  always_comb begin
    case (cmd_i.term)
      TERM_P: begin
        tval44   = {{12{err_q[31]}}, err_q};
        gain_sel = gain_p_q;
      end
      TERM_I: begin
        tval44   = {{12{integ_q[31]}}, integ_q};
        gain_sel = gain_i_q;
      end
      TERM_D: begin
        tval44   = deriv_q;
        gain_sel = gain_d_q;
      end
      default: begin
        tval44   = '0;
        gain_sel = '0;
      end
    endcase
  end

  assign tmag44 = tval44[43] ? (~tval44 + 44'd1) : tval44;
  assign mop    = cmd_i.pp[0] ? tmag_q[47:24] : tmag_q[23:0];
  assign gop    = cmd_i.pp[1] ? gain_sel[47:24] : gain_sel[23:0];
  assign pp48   = {24'd0, mop} * {24'd0, gop};

  always_comb begin
    case (cmd_i.pp)
      2'd0:    ppx = {48'd0, pp48};
      2'd3:    ppx = {pp48, 48'd0};
      default: ppx = {24'd0, pp48, 24'd0};
    endcase
  end

  assign tres56 = prod_q[95:40];

  // output saturation and minimum drive
  assign fits   = (oacc_q[55:31] == '0) || (oacc_q[55:31] == '1);
  assign osat   = fits ? oacc_q[31:0] : (oacc_q[55] ? S32_MIN : S32_MAX);
  assign omag   = osat[31] ? (~osat + 32'd1) : osat;
  assign opos   = !osat[31] && (osat != '0);
  assign bump   = !mode_q && (omag < Q_TENTH) && (err_mag > Q_TENTH);
  assign ofinal = bump ? (opos ? Q_TENTH : Q_NEG_TENTH) : osat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_error_q  <= '0;
      integral_q     <= '0;
      held_q         <= '0;
      prior_target_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        prior_error_q  <= err_q;
        integral_q     <= integ_q;
        held_q         <= ofinal;
        prior_target_q <= tgt_q;
        out_valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tgt_q <= target_rpm_i;
      us_q  <= step_time_us_i;
      err_q <= err_d;
    end
    if (cmd_i.calc_err) begin
      tchg_small_q <= tmag33 >= {1'b0, Q_TENTH};
      tchg_big_q   <= tmag33 >= {1'b0, Q_HALF};
    end
    if (cmd_i.prep) begin
      der_mag_q <= der_prod;
      der_neg_q <= ddiff33[32];
      ltf_q     <= (us_q < US_FLOOR) ? US_FLOOR : us_q;
      quo_q     <= mode_q ? {{(DIV_NUM_W-32){1'b0}}, err_mag} : int_prod;
      rem_q     <= '0;
      den_q     <= mode_q ? US_PER_MS : US_PER_S;
      dneg_q    <= err_q[31];
    end
    if (cmd_i.div_step) begin
      quo_q <= step_quo;
      rem_q <= step_rem;
    end
    if (cmd_i.int_upd) begin
      integ_q <= integ_d;
      oacc_q  <= (!mode_q && !tchg_big_q) ? {{24{held_q[31]}}, held_q} : '0;
    end
    if (cmd_i.load_der_div) begin
      quo_q  <= der_mag_q;
      rem_q  <= '0;
      den_q  <= ltf_q;
      dneg_q <= der_neg_q;
    end
    if (cmd_i.der_upd) begin
      deriv_q <= deriv_d;
    end
    if (cmd_i.term_load) begin
      tmag_q <= {4'd0, tmag44};
      tneg_q <= tval44[43];
      prod_q <= '0;
    end
    if (cmd_i.mul_step) begin
      prod_q <= prod_q + ppx;
    end
    if (cmd_i.term_add) begin
      oacc_q <= tneg_q ? (oacc_q - tres56) : (oacc_q + tres56);
    end
    if (cmd_i.finish) begin
      dout_q <= ofinal;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.mode     = mode_q;
  assign out_valid_o    = out_valid_q;
  assign drive_value_o  = dout_q;

endmodule

`default_nettype wire

[rtl/velocity_pid_controller.sv]
// Channel   Direction  Handshake            Word
// input     in         in_valid/in_ready    target_rpm, measured_rpm, step_time_us
// result    out        out_valid/out_ready  drive_value
// config    in         cfg_we (no wait)     cfg_index, cfg_data
//
// One word in flight: each word runs to its result, and the next word is taken
// only once the result is issued. Two divider passes (4 quotient bits a cycle;
// absolute mode skips the second) and three gain products on one 24x24
// multiplier make up the work.
// Reset clears the loop state and restores the default gains.
// A result waiting on out_ready holds the block before its state update.
`default_nettype none

module velocity_pid_controller
  import vpid_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [47:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] target_rpm_i,
  input  logic signed [31:0] measured_rpm_i,
  input  logic [19:0]        step_time_us_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] drive_value_o
);

  cmd_t cmd;
  sts_t sts;

  vpid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vpid_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .target_rpm_i   (target_rpm_i),
    .measured_rpm_i (measured_rpm_i),
    .step_time_us_i (step_time_us_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_value_o  (drive_value_o)
  );

endmodule

`default_nettype wire

[rtl/vpid_checker.sv]
`default_nettype none

module vpid_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] drive_value_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still ready after accepting a word");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised without a word in progress");

  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o)
    else $error("input ready returned without a result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_value_o))
    else $error("stalled result word changed");

endmodule

bind velocity_pid_controller vpid_checker u_vpid_checker (.*);

`default_nettype wire

[bench/velocity_pid_controller_test.sv]
`timescale 1ns / 1ps

module velocity_pid_controller_test;
  import vpid_pkg::*;

  localparam longint TENTH     = Q_TENTH;
  localparam longint HALF      = Q_HALF;
  localparam longint CLAMP_INC = Q_CLAMP_INC;
  localparam longint CLAMP_ABS = Q_CLAMP_ABS;
  localparam longint PER_S     = US_PER_S;
  localparam longint PER_MS    = US_PER_MS;
  localparam longint FLOOR_US  = US_FLOOR;
  localparam longint DRIVE_HI  = 64'sd2147483647;
  localparam longint DRIVE_LO  = -64'sd2147483648;
  localparam longint WEIGH_LIM = 64'sd140737488355328;
  localparam logic [47:0] GAIN_MAX = 48'hffff_ffff_ffff;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 125;

  typedef enum logic {
    ROW_WORD = 1'b0,
    ROW_REG  = 1'b1
  } row_e;

  typedef struct packed {
    logic signed [31:0] tgt;
    logic signed [31:0] meas;
    logic [19:0]        us;
  } word_t;

  typedef struct packed {
    row_e               kind;
    reg_idx_e           idx;
    logic [47:0]        data;
    word_t              w;
    logic               known;
    logic signed [31:0] want;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [47:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] target_rpm;
  logic signed [31:0] measured_rpm;
  logic [19:0]        step_time_us;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] drive_value;

  velocity_pid_controller u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .target_rpm_i   (target_rpm),
    .measured_rpm_i (measured_rpm),
    .step_time_us_i (step_time_us),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .drive_value_o  (drive_value)
  );

  // controller shadow: settings and loop state
  logic               cur_mode;
  logic [47:0]        kp, ki, kd;
  longint             last_err, err_sum, last_drive, last_target;

  logic signed [31:0] drive_due[$];
  row_t               plan[$];
  logic signed [31:0] due_now;
  int                 faults;
  int unsigned        cycles;
  int unsigned        idle_pct;
  int                 cruise;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint mag_of(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // signed value times unsigned Q8.40 gain, truncated toward zero
  function automatic longint weigh(input longint x, input logic [47:0] g);
    logic        neg;
    logic [47:0] mag;
    logic [95:0] prod;
    longint      r;
    neg  = x < 0;
    mag  = 48'(mag_of(clip(x, -WEIGH_LIM, WEIGH_LIM)));
    prod = {48'd0, mag} * {48'd0, g};
    r    = longint'({8'd0, prod[95:40]});
    return neg ? -r : r;
  endfunction

  function automatic logic signed [31:0] next_drive(input logic signed [31:0] tgt,
                                                    input logic signed [31:0] meas,
                                                    input logic [19:0] us);
    longint t, m, dt, e, dtar, span, integ, deriv, outv;
    logic   flip;
    t    = longint'(tgt);
    m    = longint'(meas);
    dt   = longint'({44'd0, us});
    e    = clip(t - m, DRIVE_LO, DRIVE_HI);
    flip = (e > 0 && last_err < 0) || (e < 0 && last_err > 0);
    if (cur_mode == 1'b0) begin
      dtar  = mag_of(t - last_target);
      span  = dt < FLOOR_US ? FLOOR_US : dt;
      integ = err_sum + (e * dt) / PER_S;
      if (flip || mag_of(e) < TENTH || dtar >= TENTH) integ = 0;
      if (dtar >= HALF) last_drive = 0;
      integ = clip(integ, -CLAMP_INC, CLAMP_INC);
      deriv = ((e - last_err) * PER_S) / span;
      outv  = last_drive + weigh(e, kp) + weigh(integ, ki) + weigh(deriv, kd);
      outv  = clip(outv, DRIVE_LO, DRIVE_HI);
      if (mag_of(outv) < TENTH && mag_of(e) > TENTH) outv = outv > 0 ? TENTH : -TENTH;
    end else begin
      integ = err_sum + e / PER_MS;
      if (flip) integ = 0;
      integ = clip(integ, -CLAMP_ABS, CLAMP_ABS);
      deriv = (e - last_err) * PER_MS;
      outv  = weigh(e, kp) + weigh(integ, ki) + weigh(deriv, kd);
      outv  = clip(outv, DRIVE_LO, DRIVE_HI);
    end
    err_sum     = integ;
    last_err    = e;
    last_target = t;
    last_drive  = outv;
    return outv[31:0];
  endfunction

  function automatic void add_word(input logic signed [31:0] t, input logic signed [31:0] m,
                                   input logic [19:0] us, input logic known,
                                   input logic signed [31:0] want);
    row_t r;
    r       = '0;
    r.kind  = ROW_WORD;
    r.w     = '{tgt: t, meas: m, us: us};
    r.known = known;
    r.want  = want;
    plan.push_back(r);
  endfunction

  function automatic void add_reg(input reg_idx_e idx, input logic [47:0] data);
    row_t r;
    r      = '0;
    r.kind = ROW_REG;
    r.idx  = idx;
    r.data = data;
    plan.push_back(r);
  endfunction

  function automatic logic signed [31:0] pole();
    case ($urandom_range(0, 3))
      0:       return S32_MAX;
      1:       return S32_MIN;
      2:       return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [47:0] pick_gain();
    logic [63:0] raw;
    case ($urandom_range(0, 4))
      0:       return 48'd0;
      1:       return GAIN_MAX;
      2:       begin
        raw = {$urandom, $urandom};
        return raw[47:0];
      end
      default: begin
        raw = {32'd0, $urandom} >> $urandom_range(0, 24);
        return raw[47:0];
      end
    endcase
  endfunction

  function automatic word_t draw_word();
    word_t w;
    int    step;
    int    jitter;
    case ($urandom_range(0, 9))
      0, 1: begin
        w.tgt  = $urandom;
        w.meas = $urandom;
        w.us   = 20'($urandom);
      end
      2: begin
        w.tgt  = pole();
        w.meas = pole();
        w.us   = $urandom_range(0, 1) ? 20'hfffff : 20'd0;
      end
      default: begin
        // hold a setpoint, move it now and then, measure close to it
        case ($urandom_range(0, 9))
          0: begin
            step   = $urandom_range(0, 13106);
            cruise = cruise + step - 6553;
          end
          1: begin
            step   = $urandom_range(6554, 40000);
            cruise = $urandom_range(0, 1) ? cruise + step : cruise - step;
          end
          2: begin
            step   = $urandom_range(0, 1 << 25);
            cruise = step - (1 << 24);
          end
          default: ;
        endcase
        jitter = $urandom_range(0, 40000);
        w.tgt  = cruise;
        w.meas = cruise + jitter - 20000;
        w.us   = ($urandom_range(0, 7) == 0) ? 20'($urandom_range(0, 3000))
                                             : 20'($urandom_range(950, 1050));
      end
    endcase
    return w;
  endfunction

  task automatic put_reg(input reg_idx_e idx, input logic [47:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_LOOP_MODE: cur_mode = data[0];
      REG_GAIN_P:    kp = data;
      REG_GAIN_I:    ki = data;
      REG_GAIN_D:    kd = data;
      default:       ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drive_due.size() != 0 || !in_ready) @(posedge clk);
  endtask

  task automatic send_word(input word_t w, input logic known, input logic signed [31:0] want);
    logic signed [31:0] forecast;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    target_rpm   <= w.tgt;
    measured_rpm <= w.meas;
    step_time_us <= w.us;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    forecast = next_drive(w.tgt, w.meas, w.us);
    drive_due.push_back(known ? want : forecast);
  endtask

  // result side: random back-pressure bursts
  initial begin
    forever begin
      @(posedge clk);
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (drive_due.size() == 0) begin
        if (faults < 10) $display("drive_value %0d returned with no word outstanding",
                                  drive_value);
        faults++;
      end else begin
        due_now = drive_due.pop_front();
        if (drive_value !== due_now) begin
          if (faults < 10) $display("drive_value mismatch: expected %0d, got %0d",
                                    due_now, drive_value);
          faults++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_LOOP_MODE;
    cfg_data     = '0;
    in_valid     = 1'b0;
    target_rpm   = '0;
    measured_rpm = '0;
    step_time_us = '0;
    out_ready    = 1'b1;
    faults       = 0;
    cycles       = 0;
    idle_pct     = 0;
    cruise       = 0;
    cur_mode     = 1'b0;
    kp           = GAIN_P_RST;
    ki           = GAIN_I_RST;
    kd           = GAIN_D_RST;
    last_err     = 0;
    err_sum      = 0;
    last_drive   = 0;
    last_target  = 0;

    add_word(32'sd0, 32'sd0, 20'd0, 1'b1, 32'sd0);
    add_word(S32_MAX, S32_MIN, 20'd0, 1'b0, 0);
    add_word(S32_MIN, S32_MAX, 20'hfffff, 1'b0, 0);
    add_word(S32_MIN, S32_MIN + 32'd100, 20'd1000, 1'b0, 0);
    add_word(S32_MIN + 32'd3000, S32_MIN - 32'd17000, 20'd999, 1'b0, 0);
    add_word(S32_MIN + 32'd3000, S32_MIN - 32'd17000, 20'd1000, 1'b0, 0);
    add_word(S32_MIN + 32'd35767, S32_MIN + 32'd3000, 20'd1000, 1'b0, 0);
    add_word(S32_MIN + 32'd68535, S32_MIN + 32'd3000, 20'd500000, 1'b0, 0);
    add_word(32'sd65536, 32'sd0, 20'd1000, 1'b0, 0);
    add_word(32'sd65536, 32'sd0, 20'd1000, 1'b0, 0);
    add_word(32'sd0, 32'sd65536, 20'd1000, 1'b0, 0);
    add_word(32'sd0, 32'sd6554, 20'd1000, 1'b0, 0);
    add_word(32'sd0, -32'sd6553, 20'd1000, 1'b0, 0);
    add_word(32'sd6553, 32'sd0, 20'd1000, 1'b0, 0);
    add_word(32'sd13107, 32'sd0, 20'd1000, 1'b0, 0);
    add_word(S32_MAX, S32_MAX, 20'd1048575, 1'b0, 0);
    add_reg(REG_LOOP_MODE, 48'd1);
    add_word(S32_MAX, S32_MIN, 20'd0, 1'b0, 0);
    add_word(S32_MAX, S32_MIN, 20'd7, 1'b0, 0);
    add_word(S32_MIN, S32_MAX, 20'd0, 1'b0, 0);
    add_word(32'sd100, 32'sd0, 20'd0, 1'b0, 0);
    add_reg(REG_GAIN_P, 48'd0);
    add_reg(REG_GAIN_I, 48'd0);
    add_reg(REG_GAIN_D, 48'd0);
    add_word(32'sd12345, -32'sd999, 20'd1, 1'b1, 32'sd0);
    add_reg(REG_LOOP_MODE, 48'd0);
    add_reg(REG_GAIN_P, GAIN_MAX);
    add_reg(REG_GAIN_I, GAIN_MAX);
    add_reg(REG_GAIN_D, GAIN_MAX);
    add_word(32'sd0, 32'sd0, 20'd1000, 1'b0, 0);
    add_word(S32_MAX, S32_MIN, 20'd1000, 1'b1, S32_MAX);
    add_word(S32_MIN, S32_MAX, 20'd1000, 1'b1, S32_MIN);
    add_word(S32_MIN, S32_MIN, 20'd0, 1'b0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 25;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        if (!cfg_we) wait_drained();
        put_reg(plan[i].idx, plan[i].data);
      end else begin
        if (cfg_we) cfg_we <= 1'b0;
        send_word(plan[i].w, plan[i].known, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      if (ph == 0) begin
        put_reg(REG_LOOP_MODE, 48'd0);
        put_reg(REG_GAIN_P, GAIN_P_RST);
        put_reg(REG_GAIN_I, GAIN_I_RST);
        put_reg(REG_GAIN_D, GAIN_D_RST);
      end else begin
        put_reg(REG_LOOP_MODE, 48'(ph % 2));
        put_reg(REG_GAIN_P, pick_gain());
        put_reg(REG_GAIN_I, pick_gain());
        put_reg(REG_GAIN_D, pick_gain());
      end
      cfg_we <= 1'b0;
      case (ph % 4)
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        2:       idle_pct = 30;
        default: idle_pct = 50;
      endcase
      if (ph == PHASES - 1) idle_pct = 0;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // halfway through the phase, hold off until the pipe is empty
        if (i == PHASE_WORDS / 2) wait_drained();
        send_word(draw_word(), 1'b0, 0);
      end
    end

    wait_drained();
    repeat (64) @(posedge clk);
    if (faults == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
